// ----- design/dsfp_pkg.sv -----
// Shared types and constants of the dust sensor frame parser.
// No dependencies; imported by the input stage, the frame core and the top level.
`default_nettype none
package dsfp_pkg;

    localparam int          FRAME_BYTES_DEF = 24;
    localparam int          POS_W           = 5;
    localparam logic [7:0]  START_BYTE      = 8'h42;

    typedef struct packed {
        logic [15:0] pm10_atmospheric;
        logic [15:0] pm25_atmospheric;
        logic [15:0] pm10_standard;
        logic [15:0] pm25_standard;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_byte_beat;

endpackage
`default_nettype wire

// ----- design/dsfp_in_stage.sv -----
// Input register of the frame parser: holds one received byte beat.
// Depends on dsfp_pkg for the beat struct.
`default_nettype none
module dsfp_in_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [7:0]          i_data,
    output dsfp_pkg::t_byte_beat     o_beat,
    input  wire logic                i_take
);
    import dsfp_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       n_valid;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_beat.valid   = r_valid;
    assign o_beat.rx_byte = r_data;

endmodule
`default_nettype wire

// ----- design/dsfp_frame_core.sv -----
// Frame state, checksum compare and result register of the frame parser.
// Depends on dsfp_pkg for the start byte, position width and result struct.
`default_nettype none
module dsfp_frame_core #(
    parameter int FRAME_BYTES = dsfp_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  dsfp_pkg::t_byte_beat     i_beat,
    output logic                     o_take,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output dsfp_pkg::t_result        o_result
);
    import dsfp_pkg::*;

    localparam logic [POS_W-1:0] CHK_HI_POS = POS_W'(FRAME_BYTES - 2);

    logic               r_in_frame;
    logic [POS_W-1:0]   r_pos;
    logic [15:0]        r_sum;
    logic [15:0]        r_cap [4];
    logic [7:0]         r_chk_hi;
    logic               r_out_valid;
    t_result            r_out;

    logic               n_in_frame;
    logic [POS_W-1:0]   n_pos;
    logic [15:0]        n_sum;
    logic [15:0]        n_cap [4];
    logic [7:0]         n_chk_hi;
    logic               n_out_valid;
    logic               hit;
    logic [1:0]         slot;
    logic               slot_hit;
    logic [7:0]         b;

    assign o_take = i_beat.valid && (!r_out_valid || i_ready);
    assign b      = i_beat.rx_byte;

    always_comb begin
        slot     = 2'd0;
        slot_hit = 1'b1;
        case (r_pos) inside
            5'd6, 5'd7:   slot = 2'd0;
            5'd8, 5'd9:   slot = 2'd1;
            5'd12, 5'd13: slot = 2'd2;
            5'd14, 5'd15: slot = 2'd3;
            default:      slot_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_cap      = r_cap;
        n_chk_hi   = r_chk_hi;
        hit        = 1'b0;
        if (o_take) begin
            if (!r_in_frame) begin
                if (b == START_BYTE) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_W'(1);
                    n_sum      = {8'd0, b};
                    n_chk_hi   = 8'd0;
                    for (int i = 0; i < 4; i++) begin
                        n_cap[i] = 16'd0;
                    end
                end
            end else if (r_pos < CHK_HI_POS) begin
                n_sum = r_sum + {8'd0, b};
                if (slot_hit) begin
                    n_cap[slot] = {r_cap[slot][7:0], b};
                end
                n_pos = r_pos + POS_W'(1);
            end else if (r_pos == CHK_HI_POS) begin
                n_chk_hi = b;
                n_pos    = r_pos + POS_W'(1);
            end else begin
                n_in_frame = 1'b0;
                n_pos      = '0;
                hit        = ({r_chk_hi, b} == r_sum);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (!r_out_valid || i_ready) begin
            n_out_valid = hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_pos       <= '0;
            r_sum       <= 16'd0;
            r_chk_hi    <= 8'd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_cap[i] <= 16'd0;
            end
        end else begin
            r_in_frame  <= n_in_frame;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_chk_hi    <= n_chk_hi;
            r_out_valid <= n_out_valid;
            r_cap       <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_out.pm25_standard    <= r_cap[0];
            r_out.pm10_standard    <= r_cap[1];
            r_out.pm25_atmospheric <= r_cap[2];
            r_out.pm10_atmospheric <= r_cap[3];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ----- design/dust_sensor_frame_parser_unit.sv -----
// Dust sensor frame parser top level: one received byte per beat in,
// one beat with the four concentration values out per good frame.
// The result is registered: it loads when the core takes the final byte of a good frame.
// Throughput: one byte per cycle; input holds while a result beat waits.
// Reset (synchronous, active low) clears frame state and both valid flags.
// Depends on dsfp_pkg, dsfp_in_stage and dsfp_frame_core.
`default_nettype none
module dust_sensor_frame_parser_unit #(
    parameter int FRAME_BYTES = dsfp_pkg::FRAME_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata    // [15:0] pm25_standard, [31:16] pm10_standard,
                                          // [47:32] pm25_atmospheric, [63:48] pm10_atmospheric
);
    import dsfp_pkg::*;

    t_byte_beat beat;
    logic       take;
    t_result    result;

    dsfp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_beat  (beat),
        .i_take  (take)
    );

    dsfp_frame_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (beat),
        .o_take   (take),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result)
    );

    assign o_m_tdata = result;

endmodule
`default_nettype wire
